@@ hw/rtl/cubic_bezier_point_eval_macros.svh @@
// Assertion macros used by the checker file.
`ifndef CUBIC_BEZIER_POINT_EVAL_MACROS_SVH
`define CUBIC_BEZIER_POINT_EVAL_MACROS_SVH

// Check an implication that holds in the same cycle.
`define CBEZ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication whose consequence lands in the next cycle.
`define CBEZ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cbez_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cbez_pkg;

    // Fraction bits of the curve parameter
    localparam int T_FRAC_BITS = 12;

    // Coordinate width (signed Q4.12)
    localparam int CRD_W = 16;

    // Derived datapath widths
    localparam int TW = T_FRAC_BITS;           // t
    localparam int UW = T_FRAC_BITS + 1;       // u = 1 - t, may equal one
    localparam int W2 = 2 * T_FRAC_BITS + 1;   // u*u, u*t, t*t
    localparam int WW = 3 * T_FRAC_BITS + 1;   // basis weights
    localparam int PW = WW + 1 + CRD_W;        // weight times coordinate
    localparam int SW = PW + 2;                // sum of four products
    localparam int SHIFT = 3 * T_FRAC_BITS;    // scale of the weight sum

    localparam logic [UW-1:0] T_ONE = UW'(1) << T_FRAC_BITS;

    // Configuration register map
    localparam int NUM_REGS = 8;
    localparam int CFG_IDX_W = 4;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_P0_X = cfg_idx_t'(0);
    localparam cfg_idx_t REG_P0_Y = cfg_idx_t'(1);
    localparam cfg_idx_t REG_P1_X = cfg_idx_t'(2);
    localparam cfg_idx_t REG_P1_Y = cfg_idx_t'(3);
    localparam cfg_idx_t REG_P2_X = cfg_idx_t'(4);
    localparam cfg_idx_t REG_P2_Y = cfg_idx_t'(5);
    localparam cfg_idx_t REG_P3_X = cfg_idx_t'(6);
    localparam cfg_idx_t REG_P3_Y = cfg_idx_t'(7);

    typedef logic signed [CRD_W-1:0] crd_t;

    localparam crd_t RST_P0_X = -16'sd4096;
    localparam crd_t RST_P0_Y = 16'sd4096;
    localparam crd_t RST_P1_X = -16'sd2048;
    localparam crd_t RST_P1_Y = 16'sd2048;
    localparam crd_t RST_P2_X = 16'sd0;
    localparam crd_t RST_P2_Y = 16'sd0;
    localparam crd_t RST_P3_X = 16'sd2048;
    localparam crd_t RST_P3_Y = -16'sd2048;

endpackage

`default_nettype wire

@@ hw/rtl/cubic_bezier_point_eval.sv @@
// An accepted transaction moves through stages s1 to s4 into the output register.
// Throughput: one point per clock; the five-stage multiply pipeline takes a
// new t every cycle and stalls as a whole only while a held result is stalled.
// Reset: rst_n clears all stage valid bits and loads the default control points.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_point_eval
    import cbez_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CRD_W-1:0]         cfg_data,

    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [TW-1:0]            param_t,

    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [CRD_W-1:0]       point_x,
    output logic signed [CRD_W-1:0]       point_y
);

    // Control point registers
    crd_t p0_x_reg, p0_y_reg, p1_x_reg, p1_y_reg;
    crd_t p2_x_reg, p2_y_reg, p3_x_reg, p3_y_reg;

    // Pipeline valid bits
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic advance;

    // Stage 1: t and u = 1 - t
    logic [TW-1:0] s1_t_reg;
    logic [UW-1:0] s1_u_reg, s1_u_next;

    // Stage 2: second-order products
    logic [TW-1:0] s2_t_reg;
    logic [UW-1:0] s2_u_reg;
    logic [W2-1:0] s2_uu_reg, s2_uu_next;
    logic [W2-1:0] s2_tt_reg, s2_tt_next;

    // Stage 3: Bernstein weights
    logic [WW-1:0] s3_w_reg [4];
    logic [WW-1:0] s3_w_next [4];
    logic [WW-1:0] uut, utt;

    // Stage 4: weighted coordinates
    logic signed [PW-1:0] s4_px_reg [4];
    logic signed [PW-1:0] s4_py_reg [4];
    logic signed [PW-1:0] s4_px_next [4];
    logic signed [PW-1:0] s4_py_next [4];
    crd_t cx [4];
    crd_t cy [4];

    // Stage 5: sums and output
    logic signed [SW-1:0] sum_x, sum_y;
    crd_t point_x_reg, point_y_reg;

    // Move the whole pipeline unless a finished point is held
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    // Write control points
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_x_reg <= RST_P0_X;
            p0_y_reg <= RST_P0_Y;
            p1_x_reg <= RST_P1_X;
            p1_y_reg <= RST_P1_Y;
            p2_x_reg <= RST_P2_X;
            p2_y_reg <= RST_P2_Y;
            p3_x_reg <= RST_P3_X;
            p3_y_reg <= RST_P3_Y;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_P0_X: p0_x_reg <= cfg_data;
                REG_P0_Y: p0_y_reg <= cfg_data;
                REG_P1_X: p1_x_reg <= cfg_data;
                REG_P1_Y: p1_y_reg <= cfg_data;
                REG_P2_X: p2_x_reg <= cfg_data;
                REG_P2_Y: p2_y_reg <= cfg_data;
                REG_P3_X: p3_x_reg <= cfg_data;
                REG_P3_Y: p3_y_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    // Datapath arithmetic
    always_comb
    begin
        s1_u_next  = T_ONE - UW'(param_t);
        s2_uu_next = W2'(s1_u_reg) * W2'(s1_u_reg);
        s2_tt_next = W2'(s1_t_reg) * W2'(s1_t_reg);

        uut = WW'(s2_uu_reg) * WW'(s2_t_reg);
        utt = WW'(s2_tt_reg) * WW'(s2_u_reg);
        s3_w_next[0] = WW'(s2_uu_reg) * WW'(s2_u_reg);
        s3_w_next[1] = uut + (uut << 1);
        s3_w_next[2] = utt + (utt << 1);
        s3_w_next[3] = WW'(s2_tt_reg) * WW'(s2_t_reg);

        cx[0] = p0_x_reg;  cy[0] = p0_y_reg;
        cx[1] = p1_x_reg;  cy[1] = p1_y_reg;
        cx[2] = p2_x_reg;  cy[2] = p2_y_reg;
        cx[3] = p3_x_reg;  cy[3] = p3_y_reg;
        for (int k = 0; k < 4; k++)
        begin
            s4_px_next[k] = PW'($signed({1'b0, s3_w_reg[k]})) * PW'(cx[k]);
            s4_py_next[k] = PW'($signed({1'b0, s3_w_reg[k]})) * PW'(cy[k]);
        end

        sum_x = SW'(s4_px_reg[0]) + SW'(s4_px_reg[1])
              + SW'(s4_px_reg[2]) + SW'(s4_px_reg[3]);
        sum_y = SW'(s4_py_reg[0]) + SW'(s4_py_reg[1])
              + SW'(s4_py_reg[2]) + SW'(s4_py_reg[3]);
    end

    // Hold payload on stall, load on advance
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_t_reg    <= param_t;
            s1_u_reg    <= s1_u_next;
            s2_t_reg    <= s1_t_reg;
            s2_u_reg    <= s1_u_reg;
            s2_uu_reg   <= s2_uu_next;
            s2_tt_reg   <= s2_tt_next;
            for (int k = 0; k < 4; k++)
            begin
                s3_w_reg[k]  <= s3_w_next[k];
                s4_px_reg[k] <= s4_px_next[k];
                s4_py_reg[k] <= s4_py_next[k];
            end
            // Drop the scale bits: floor to Q4.12
            point_x_reg <= sum_x[SHIFT+CRD_W-1:SHIFT];
            point_y_reg <= sum_y[SHIFT+CRD_W-1:SHIFT];
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;

endmodule

`default_nettype wire

@@ hw/rtl/cbez_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "cubic_bezier_point_eval_macros.svh"

module cbez_checker
    import cbez_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire logic [CRD_W-1:0]     point_x,
    input  wire logic [CRD_W-1:0]     point_y
);

    logic in_acc, idle_cyc;

    assign in_acc   = in_valid && !in_stall;
    assign idle_cyc = !in_acc && !out_stall;

    // Output transaction stays offered while stalled
    `CBEZ_ASSERT_NEXT(a_out_valid_hold, clk, rst_n,
        out_valid && out_stall, out_valid,
        "out_valid dropped under stall")

    // Stalled point holds its value
    `CBEZ_ASSERT_NEXT(a_out_data_hold, clk, rst_n,
        out_valid && out_stall, $stable(point_x) && $stable(point_y),
        "point changed under stall")

    // Input backs up only behind a held output
    `CBEZ_ASSERT_NOW(a_in_stall_cause, clk, rst_n,
        in_stall, out_valid && out_stall,
        "input stalled while output free")

    // Free cycles with no new transaction drain every stage of the pipeline
    `CBEZ_ASSERT_NEXT(a_drain, clk, rst_n,
        idle_cyc ##1 idle_cyc ##1 idle_cyc ##1 idle_cyc ##1 idle_cyc, !out_valid,
        "output without an accepted transaction")

endmodule

bind cubic_bezier_point_eval cbez_checker u_cbez_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .point_x   (point_x),
    .point_y   (point_y)
);

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import cbez_pkg::*;

    localparam crd_t CRD_MIN = -16'sd32768;
    localparam crd_t CRD_MAX = 16'sd32767;
    localparam logic [TW-1:0] T_LAST = {TW{1'b1}};

    // Control point sets used by the directed table
    localparam logic [1:0] SET_RESET = 2'd0;
    localparam logic [1:0] SET_ALL_MIN = 2'd1;
    localparam logic [1:0] SET_ALL_MAX = 2'd2;
    localparam logic [1:0] SET_SWING = 2'd3;

    localparam int NUM_DIR_ROWS = 21;
    localparam int NUM_PHASES = 8;
    localparam int POINTS_PER_PHASE = 75;
    localparam int DRAIN_CYCLES = 10;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

    typedef struct packed {
        crd_t x;
        crd_t y;
    } curve_point_t;

    typedef struct packed {
        logic [1:0]    set_sel;
        logic [TW-1:0] t;
        logic          typed;
        crd_t          x;
        crd_t          y;
    } dir_row_t;

    logic           clk;
    logic           rst_n;
    logic           cfg_we;
    cfg_idx_t       cfg_index;
    logic [CRD_W-1:0] cfg_data;
    logic           in_valid;
    logic           in_stall;
    logic [TW-1:0]  param_t;
    logic           out_valid;
    logic           out_stall = 1'b0;
    crd_t           point_x;
    crd_t           point_y;

    // Typed-in expectation travels with its transaction
    logic           item_typed;
    crd_t           item_x;
    crd_t           item_y;

    crd_t           ctl_reg [NUM_REGS];
    crd_t           staged_pts [NUM_REGS];
    curve_point_t   expected_pts [$];
    int             mismatch_count = 0;
    int             burst_left = 0;
    int             gap_max = 0;
    stall_mode_t    stall_mode = STALL_NONE;
    logic [3:0]     stall_tick = '0;

    // Directed rows: t at zero lands on P0, all-equal points give that point exactly
    dir_row_t dir_rows [NUM_DIR_ROWS] = '{
        '{SET_RESET,   12'd0,    1'b1, RST_P0_X, RST_P0_Y},
        '{SET_RESET,   T_LAST,   1'b0, 16'sd0,   16'sd0},
        '{SET_RESET,   12'd1,    1'b0, 16'sd0,   16'sd0},
        '{SET_RESET,   12'h800,  1'b0, 16'sd0,   16'sd0},
        '{SET_RESET,   12'hAAA,  1'b0, 16'sd0,   16'sd0},
        '{SET_RESET,   12'h555,  1'b0, 16'sd0,   16'sd0},
        '{SET_RESET,   12'd0,    1'b1, RST_P0_X, RST_P0_Y},
        '{SET_ALL_MIN, 12'd0,    1'b1, CRD_MIN,  CRD_MIN},
        '{SET_ALL_MIN, T_LAST,   1'b1, CRD_MIN,  CRD_MIN},
        '{SET_ALL_MIN, 12'h800,  1'b1, CRD_MIN,  CRD_MIN},
        '{SET_ALL_MAX, 12'd0,    1'b1, CRD_MAX,  CRD_MAX},
        '{SET_ALL_MAX, T_LAST,   1'b1, CRD_MAX,  CRD_MAX},
        '{SET_ALL_MAX, 12'd1365, 1'b1, CRD_MAX,  CRD_MAX},
        '{SET_SWING,   12'd0,    1'b1, CRD_MIN,  CRD_MAX},
        '{SET_SWING,   T_LAST,   1'b0, 16'sd0,   16'sd0},
        '{SET_SWING,   12'h800,  1'b0, 16'sd0,   16'sd0},
        '{SET_SWING,   12'd1,    1'b0, 16'sd0,   16'sd0},
        '{SET_SWING,   12'd3000, 1'b0, 16'sd0,   16'sd0},
        '{SET_RESET,   12'd0,    1'b1, RST_P0_X, RST_P0_Y},
        '{SET_RESET,   T_LAST,   1'b0, 16'sd0,   16'sd0},
        '{SET_RESET,   12'd1024, 1'b0, 16'sd0,   16'sd0}
    };

    cubic_bezier_point_eval dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .param_t   (param_t),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .point_x   (point_x),
        .point_y   (point_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic crd_t reset_coord(input cfg_idx_t idx);
        case (idx)
            REG_P0_X: return RST_P0_X;
            REG_P0_Y: return RST_P0_Y;
            REG_P1_X: return RST_P1_X;
            REG_P1_Y: return RST_P1_Y;
            REG_P2_X: return RST_P2_X;
            REG_P2_Y: return RST_P2_Y;
            REG_P3_X: return RST_P3_X;
            default:  return RST_P3_Y;
        endcase
    endfunction

    // Control point coordinate of a directed set; even indexes are x
    function automatic crd_t set_coord(input logic [1:0] sel, input int idx);
        case (sel)
            SET_RESET:   return reset_coord(cfg_idx_t'(idx));
            SET_ALL_MIN: return CRD_MIN;
            SET_ALL_MAX: return CRD_MAX;
            default:     return ((idx < 4) == (idx % 2 == 0)) ? CRD_MIN : CRD_MAX;
        endcase
    endfunction

    // Bernstein blend of the current control points, floored to Q4.12
    function automatic curve_point_t eval_point(input logic [TW-1:0] t);
        longint signed tv;
        longint signed uv;
        longint signed acc_x;
        longint signed acc_y;
        longint signed w [4];
        curve_point_t p;
        int k;
        tv = longint'(t);
        uv = (longint'(1) <<< T_FRAC_BITS) - tv;
        w[0] = uv * uv * uv;
        w[1] = 3 * uv * uv * tv;
        w[2] = 3 * uv * tv * tv;
        w[3] = tv * tv * tv;
        acc_x = 0;
        acc_y = 0;
        for (k = 0; k < 4; k++)
        begin
            acc_x += w[k] * longint'(ctl_reg[2 * k]);
            acc_y += w[k] * longint'(ctl_reg[2 * k + 1]);
        end
        p.x = crd_t'(acc_x >>> SHIFT);
        p.y = crd_t'(acc_y >>> SHIFT);
        return p;
    endfunction

    function automatic logic [TW-1:0] rand_param();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return T_LAST;
            2:       return TW'($urandom_range(0, 15));
            3:       return T_LAST - TW'($urandom_range(0, 15));
            default: return TW'($urandom_range(0, 2 ** TW - 1));
        endcase
    endfunction

    function automatic crd_t rand_coord();
        case ($urandom_range(0, 5))
            0:       return CRD_MIN;
            1:       return CRD_MAX;
            2:       return crd_t'($signed($urandom_range(0, 8191)) - 4096);
            default: return crd_t'($urandom);
        endcase
    endfunction

    // Track register writes, queue expected points, check the output
    always @(posedge clk)
    begin : track_points
        curve_point_t want;
        curve_point_t got;
        int r;
        if (!rst_n)
        begin
            for (r = 0; r < NUM_REGS; r++)
                ctl_reg[r] = reset_coord(cfg_idx_t'(r));
        end
        else
        begin
            if (cfg_we && cfg_index < NUM_REGS)
                ctl_reg[cfg_index] = crd_t'(cfg_data);
            if (in_valid && !in_stall)
            begin
                if (item_typed)
                begin
                    want.x = item_x;
                    want.y = item_y;
                end
                else
                    want = eval_point(param_t);
                expected_pts.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_pts.size() == 0)
                begin
                    $error("unexpected point: x %0d, y %0d", point_x, point_y);
                    mismatch_count++;
                end
                else
                begin
                    got = expected_pts.pop_front();
                    if (point_x !== got.x)
                    begin
                        $error("point_x: expected %0d, got %0d", $signed(got.x), point_x);
                        mismatch_count++;
                    end
                    if (point_y !== got.y)
                    begin
                        $error("point_y: expected %0d, got %0d", $signed(got.y), point_y);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Output stall pattern, chosen per phase
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 4'd1;
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: out_stall <= (stall_tick >= 4'd10);
            default:        out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // Present one transaction and hold it until accepted
    task automatic send_point(input logic [TW-1:0] t, input logic typed,
                              input crd_t ex, input crd_t ey);
        in_valid   <= 1'b1;
        param_t    <= t;
        item_typed <= typed;
        item_x     <= ex;
        item_y     <= ey;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Insert a random gap at the end of each burst
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop valid and wait until every expected point has come out
    task automatic drain_points();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_pts.size() != 0)
            @(posedge clk);
    endtask

    // Write all staged control points, then one write past the register map
    task automatic load_points();
        int i;
        for (i = 0; i < NUM_REGS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= staged_pts[i];
            @(posedge clk);
        end
        cfg_index <= cfg_idx_t'($urandom_range(NUM_REGS, 2 ** CFG_IDX_W - 1));
        cfg_data  <= CRD_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : run_points
        logic [1:0] cur_set;
        int row;
        int phase;
        int n;
        int i;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        param_t    = '0;
        item_typed = 1'b0;
        item_x     = '0;
        item_y     = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, reloading control points when the set changes
        stall_mode <= STALL_LIGHT;
        gap_max = 3;
        cur_set = SET_RESET;
        for (row = 0; row < NUM_DIR_ROWS; row++)
        begin
            if (dir_rows[row].set_sel != cur_set)
            begin
                drain_points();
                cur_set = dir_rows[row].set_sel;
                for (i = 0; i < NUM_REGS; i++)
                    staged_pts[i] = set_coord(cur_set, i);
                load_points();
            end
            send_point(dir_rows[row].t, dir_rows[row].typed, dir_rows[row].x, dir_rows[row].y);
            pace_sender();
        end
        drain_points();

        // Random phases, each with new control points and its own pacing
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            for (i = 0; i < NUM_REGS; i++)
                staged_pts[i] = rand_coord();
            load_points();
            stall_mode <= stall_mode_t'(phase % 4);
            gap_max = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 2 : 8);
            for (n = 0; n < POINTS_PER_PHASE; n++)
            begin
                send_point(rand_param(), 1'b0, 16'sd0, 16'sd0);
                pace_sender();
            end
            drain_points();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/cbez_pkg.sv
hw/rtl/cubic_bezier_point_eval.sv
hw/rtl/cbez_checker.sv
dv/tb_top.sv
